### hdl/skit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skit_pkg: shared types and constants of the sorted key index table
// Table geometry, command and status codes, channel items and cell controls.
// ----------------------------------------------------------------------------
package skit_pkg;

  localparam int CAP   = 256;
  localparam int RID_W = 32;
  localparam int CNT_W = $clog2(CAP + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_DUPLICATE = 2'd2;
  localparam logic [1:0] STS_FULL      = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] key;
    logic [31:0]        rid_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] rid_out;
    logic [8:0]  entry_count;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               cmp;
    logic               ins;
    logic               del;
    logic signed [31:0] key;
    logic [RID_W-1:0]   rid;
  } cell_ctrl_t;

endpackage

### hdl/skit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skit_cell: one entry of the sorted table
// Holds a key and identifier, compares against the broadcast key and
// shifts up or down with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module skit_cell (
  input  logic                      clk,
  input  skit_pkg::cell_ctrl_t      ctrl,
  input  logic                      valid,
  input  logic                      prev_lt,
  input  logic signed [31:0]        prev_key,
  input  logic [skit_pkg::RID_W-1:0] prev_rid,
  input  logic signed [31:0]        next_key,
  input  logic [skit_pkg::RID_W-1:0] next_rid,
  output logic signed [31:0]        key,
  output logic [skit_pkg::RID_W-1:0] rid,
  output logic                      lt,
  output logic                      eq,
  output logic [skit_pkg::RID_W-1:0] rid_sel
);
  import skit_pkg::*;

  logic signed [31:0] key_r;
  logic [RID_W-1:0]   rid_r;
  logic               lt_r;
  logic               eq_r;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt_r <= valid && (key_r < ctrl.key);
      eq_r <= valid && (key_r == ctrl.key);
    end
  end

  // Cells at or above the lower bound move; those below it keep their entry.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt_r) begin
      if (prev_lt) begin
        key_r <= ctrl.key;
        rid_r <= ctrl.rid;
      end else begin
        key_r <= prev_key;
        rid_r <= prev_rid;
      end
    end else if (ctrl.del && !lt_r) begin
      key_r <= next_key;
      rid_r <= next_rid;
    end
  end

  assign key     = key_r;
  assign rid     = rid_r;
  assign lt      = lt_r;
  assign eq      = eq_r;
  assign rid_sel = eq_r ? rid_r : '0;

endmodule

### hdl/sorted_key_index_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_index_table_top: sorted key table with insert, delete and find
// Keeps unique signed keys with record identifiers in ascending order in a
// row of cells, one per entry.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one command item (insert, delete or find) with a key
//   and, for insert, a record identifier. The out_ channel returns one item
//   per command: a status, the found identifier and the entry count after it.
//   In the accept cycle every cell compares its key with the new key. The
//   compare result is registered, and in the execute state the cells shift by
//   one place for an insert or delete while the result item is registered for
//   out_. The block takes no new item until the current one has left the
//   execute state; the compare and the shift of the cell row are separate steps.
//   A new item is accepted while an earlier result still waits on out_. If
//   the receiver stalls, the execute cycle waits and the table is not touched
//   until the output register is free.
//   Reset empties the table at once (count to zero) and drops any result
//   that has not been taken.
// ----------------------------------------------------------------------------
module sorted_key_index_table_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  skit_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output skit_pkg::out_item_t out_item
);
  import skit_pkg::*;

  state_t           state_r, state_nxt;
  logic [1:0]       cmd_r;
  logic [RID_W-1:0] rid_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             accept, commit, hit, full, is_find, do_ins, do_del;
  cell_ctrl_t       ctrl;

  logic signed [31:0] key_q [CAP];
  logic [RID_W-1:0]   rid_q [CAP];
  logic [RID_W-1:0]   sel_q [CAP];
  logic [CAP-1:0]     lt_vec, eq_vec, valid_vec;
  logic [RID_W-1:0]   found;

  assign accept = in_valid && in_ready;
  assign commit = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign hit     = |eq_vec;
  assign full    = (count_r == CNT_W'(CAP));
  assign is_find = cmd_r[1];
  assign do_ins  = !is_find && (cmd_r[0] == CMD_INSERT[0]) && !hit && !full;
  assign do_del  = !is_find && (cmd_r[0] == CMD_DELETE[0]) && hit;

  assign ctrl.cmp = accept;
  assign ctrl.ins = commit && do_ins;
  assign ctrl.del = commit && do_del;
  assign ctrl.key = in_item.key;
  assign ctrl.rid = rid_r;

  // The inserted key is the broadcast key, which must hold from accept to
  // commit; it is latched from the input for the commit cycle.
  logic signed [31:0] key_r;
  cell_ctrl_t         cell_ctrl;

  always_comb begin
    cell_ctrl     = ctrl;
    cell_ctrl.key = accept ? in_item.key : key_r;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
      logic                  p_lt;
      logic signed [31:0]    p_key;
      logic [RID_W-1:0]      p_rid;
      logic signed [31:0]    n_key;
      logic [RID_W-1:0]      n_rid;

      assign valid_vec[gi] = (IDX < count_r);

      if (gi == 0) begin : g_first
        assign p_lt  = 1'b1;
        assign p_key = '0;
        assign p_rid = '0;
      end else begin : g_prev
        assign p_lt  = lt_vec[gi-1];
        assign p_key = key_q[gi-1];
        assign p_rid = rid_q[gi-1];
      end

      if (gi == CAP - 1) begin : g_last
        assign n_key = '0;
        assign n_rid = '0;
      end else begin : g_next
        assign n_key = key_q[gi+1];
        assign n_rid = rid_q[gi+1];
      end

      skit_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .valid    (valid_vec[gi]),
        .prev_lt  (p_lt),
        .prev_key (p_key),
        .prev_rid (p_rid),
        .next_key (n_key),
        .next_rid (n_rid),
        .key      (key_q[gi]),
        .rid      (rid_q[gi]),
        .lt       (lt_vec[gi]),
        .eq       (eq_vec[gi]),
        .rid_sel  (sel_q[gi])
      );
    end
  endgenerate

  // At most one cell matches, so an OR over the masked identifiers selects it.
  always_comb begin
    found = '0;
    for (int i = 0; i < CAP; i++) begin
      found = found | sel_q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item.command;
      key_r <= in_item.key;
      rid_r <= RID_W'(in_item.rid_in);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (do_ins) begin
            count_nxt = count_r + 1'b1;
          end else if (do_del) begin
            count_nxt = count_r - 1'b1;
          end
          out_item_nxt.rid_out = '0;
          if (is_find) begin
            out_item_nxt.status = hit ? STS_OK : STS_NOT_FOUND;
            if (hit) begin
              out_item_nxt.rid_out = 32'(found);
            end
          end else if (cmd_r[0] == CMD_DELETE[0]) begin
            out_item_nxt.status = hit ? STS_OK : STS_NOT_FOUND;
          end else if (hit) begin
            out_item_nxt.status = STS_DUPLICATE;
          end else if (full) begin
            out_item_nxt.status = STS_FULL;
          end else begin
            out_item_nxt.status = STS_OK;
          end
          out_item_nxt.entry_count = 9'(count_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAP))
    else $error("entry count exceeds table capacity");

  a_lt_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> (((lt_vec + 1'b1) & lt_vec) == '0))
    else $error("less-than flags are not a prefix: table out of order");

  a_eq_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && do_ins) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the table by one");

  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && do_del) |=> (count_r == $past(count_r) - 1'b1))
    else $error("delete did not shrink the table by one");
`endif

endmodule

### verif/skit_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skit_tb_pkg: reply checking for the sorted key index table
// Keeps its own sorted copy of the table and predicts the reply to every
// accepted command. Each reply that arrives is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
package skit_tb_pkg;
  import skit_pkg::*;

  // The block decodes everything with the high command bit set as a find.
  localparam logic [1:0] CMD_FIND  = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic signed [31:0] key;
    logic [RID_W-1:0]   rid;
  } entry_t;

  class sorted_table_checker;
    entry_t      rows[$];
    out_item_t   awaited_replies[$];
    int unsigned mismatches;
    int unsigned peak_fill;
    int unsigned cmd_seen[4];
    int unsigned status_seen[4];

    // First place whose key is not less than k.
    function int unsigned lower_bound(logic signed [31:0] k);
      int unsigned pos;
      pos = 0;
      while (pos < rows.size() && rows[pos].key < k) pos++;
      return pos;
    endfunction

    function void note_command(in_item_t cmd);
      out_item_t   reply;
      entry_t      fresh;
      int unsigned pos;
      bit          hit;
      pos = lower_bound(cmd.key);
      hit = (pos < rows.size()) && (rows[pos].key == cmd.key);
      reply = '0;
      reply.status = STS_OK;
      cmd_seen[cmd.command]++;
      if (cmd.command == CMD_INSERT) begin
        // A duplicate is reported even when the table is also full.
        if (hit) begin
          reply.status = STS_DUPLICATE;
        end else if (rows.size() >= CAP) begin
          reply.status = STS_FULL;
        end else begin
          fresh.key = cmd.key;
          fresh.rid = cmd.rid_in;
          rows.insert(int'(pos), fresh);
        end
      end else if (cmd.command == CMD_DELETE) begin
        if (!hit) reply.status = STS_NOT_FOUND;
        else rows.delete(int'(pos));
      end else begin
        if (!hit) reply.status = STS_NOT_FOUND;
        else reply.rid_out = rows[pos].rid;
      end
      reply.entry_count = 9'(rows.size());
      if (rows.size() > peak_fill) peak_fill = rows.size();
      status_seen[reply.status]++;
      awaited_replies.push_back(reply);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR at %0t: reply with none awaited: status %0d rid %h count %0d",
                   $time, got.status, got.rid_out, got.entry_count);
        end
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status || got.rid_out !== want.rid_out ||
          got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR at %0t: expected status %0d rid %h count %0d,",
                   $time, want.status, want.rid_out, want.entry_count);
          $display("  got status %0d rid %h count %0d",
                   got.status, got.rid_out, got.entry_count);
        end
      end
    endfunction
  endclass

endpackage

### verif/sorted_key_index_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_index_table_top_tb: testbench of the sorted key index table
// Sends insert, delete and find commands with directed edge keys and then
// random traffic that fills the table to capacity and drains it again, with
// random idling on both channels and long receiver stalls. Every reply is
// checked against a predicted copy of the table.
// ----------------------------------------------------------------------------
module sorted_key_index_table_top_tb;
  import skit_pkg::*;
  import skit_tb_pkg::*;

  localparam int IDLE_PCT       = 18;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1050;

  localparam logic signed [31:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam logic signed [31:0] KEY_MIN = 32'h8000_0000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  sorted_table_checker tracker = new();
  logic        steady     = 1'b0;
  int unsigned stall_reqs = 0;
  int unsigned sent       = 0;

  sorted_key_index_table_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_item(input in_item_t cmd);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_command(cmd);
    sent++;
  endtask

  task automatic send(input logic [1:0] op, input logic signed [31:0] k,
                      input logic [31:0] rid);
    in_item_t cmd;
    cmd.command = op;
    cmd.key     = k;
    cmd.rid_in  = rid;
    send_item(cmd);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.awaited_replies.size() != 0) @(posedge clk);
  endtask

  // Keys mostly come from live entries or a narrow band so that hits,
  // duplicates and neighbors in the sorted order are common.
  function automatic logic signed [31:0] draw_key(int hit_pct);
    int unsigned sel;
    sel = $urandom_range(99);
    if (tracker.rows.size() != 0 && sel < hit_pct)
      return tracker.rows[$urandom_range(tracker.rows.size() - 1)].key;
    sel = $urandom_range(99);
    if (sel < 45) return $signed($urandom_range(400)) - 200;
    if (sel < 50) return sel[0] ? KEY_MAX : KEY_MIN;
    return $urandom();
  endfunction

  function automatic in_item_t draw_command(int ins_pct, int del_pct,
                                            int ins_hit, int look_hit);
    in_item_t    cmd;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < ins_pct) cmd.command = CMD_INSERT;
    else if (sel < ins_pct + del_pct) cmd.command = CMD_DELETE;
    else if (sel < 96) cmd.command = CMD_FIND;
    else cmd.command = CMD_SPARE;
    cmd.key    = draw_key((cmd.command == CMD_INSERT) ? ins_hit : look_hit);
    cmd.rid_in = $urandom();
    return cmd;
  endfunction

  // Stops early once the table holds stop_at entries; a negative value never stops.
  task automatic run_phase(int unsigned n, int ins_pct, int del_pct,
                           int ins_hit, int look_hit, int stop_at);
    for (int unsigned i = 0; i < n; i++) begin
      if (stop_at >= 0 && tracker.rows.size() == stop_at) break;
      send_item(draw_command(ins_pct, del_pct, ins_hit, look_hit));
    end
  endtask

  initial begin : reply_side
    int unsigned hold_left;
    int unsigned stalls_done;
    hold_left   = 0;
    stalls_done = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) tracker.check_reply(out_item);
      if (hold_left == 0 && stalls_done != stall_reqs) begin
        stalls_done = stall_reqs;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, key extremes, duplicate, misses and the spare command code.
    send(CMD_FIND,   0,           32'h0);
    send(CMD_DELETE, KEY_MIN,     32'h0);
    send(CMD_INSERT, KEY_MAX,     32'hFFFF_FFFF);
    send(CMD_INSERT, KEY_MIN,     32'h0);
    send(CMD_INSERT, 0,           32'h1234_5678);
    send(CMD_INSERT, -1,          32'hA5A5_A5A5);
    send(CMD_INSERT, 1,           32'h5A5A_5A5A);
    send(CMD_INSERT, 0,           32'hDEAD_BEEF);
    send(CMD_FIND,   KEY_MIN,     32'hFFFF_FFFF);
    send(CMD_FIND,   KEY_MAX,     32'h0);
    send(CMD_FIND,   -1,          32'h0);
    send(CMD_SPARE,  1,           32'h0);
    send(CMD_SPARE,  2,           32'h0);
    send(CMD_FIND,   KEY_MAX - 1, 32'h0);
    send(CMD_DELETE, 2,           32'h0);
    send(CMD_DELETE, KEY_MIN,     32'h0);
    send(CMD_DELETE, KEY_MAX,     32'h0);
    send(CMD_DELETE, 0,           32'h0);
    send(CMD_FIND,   0,           32'h0);
    send(CMD_INSERT, KEY_MIN,     32'h8000_0001);
    send(CMD_FIND,   KEY_MIN,     32'h0);
    send(CMD_DELETE, -1,          32'h0);
    send(CMD_DELETE, 1,           32'h0);
    send(CMD_DELETE, KEY_MIN,     32'h0);
    wait_drained();

    // Mixed traffic; the receiver holds off while commands keep coming.
    run_phase(60, 45, 25, 15, 50, -1);
    stall_reqs <= stall_reqs + 1;
    run_phase(100, 45, 25, 15, 50, -1);
    wait_drained();
    run_phase(160, 45, 25, 15, 50, -1);

    // Fill to capacity, then hit the full table with new and duplicate keys.
    run_phase(700, 92, 3, 5, 50, CAP);
    run_phase(40, 80, 0, 55, 60, -1);
    wait_drained();

    // Drain, first without any idling on either side.
    steady <= 1'b1;
    run_phase(150, 10, 80, 20, 75, 0);
    steady <= 1'b0;
    run_phase(300, 10, 80, 20, 75, 0);
    wait_drained();

    stall_reqs <= stall_reqs + 1;
    run_phase((sent < ITEM_TARGET) ? ITEM_TARGET - sent : 0, 40, 30, 20, 50, -1);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d commands: %0d insert, %0d delete, %0d find, %0d spare code;",
             sent, tracker.cmd_seen[CMD_INSERT], tracker.cmd_seen[CMD_DELETE],
             tracker.cmd_seen[CMD_FIND], tracker.cmd_seen[CMD_SPARE]);
    $display("Peak fill %0d of %0d. Replies: %0d ok, %0d not found, %0d duplicate,",
             tracker.peak_fill, CAP, tracker.status_seen[STS_OK],
             tracker.status_seen[STS_NOT_FOUND], tracker.status_seen[STS_DUPLICATE]);
    $display("  %0d full; %0d mismatches",
             tracker.status_seen[STS_FULL], tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.awaited_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
